// ===== sv/ipv4_prefix_trie_lookup_top_macros.svh =====
// ----------------------------------------------------------------------------
// IPv4 prefix trie lookup assertion macros
// Concurrent check macros used by the trie lookup top level.
// ----------------------------------------------------------------------------
`ifndef IPV4_PREFIX_TRIE_LOOKUP_TOP_MACROS_SVH
`define IPV4_PREFIX_TRIE_LOOKUP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define IPT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trie lookup check failed");
`define IPT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trie lookup check failed");
`else
`define IPT_ASSERT_IMP(name, clk, rst, ante, cons)
`define IPT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== sv/iptrie_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 prefix trie package
// Status codes, op codes and the control state type shared by the trie lookup design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iptrie_pkg;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOMATCH = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

// ===== sv/ipv4_prefix_trie_lookup_top.sv =====
// A word walks the trie one level at a time from the start edge to the done strobe, down
// to at most prefix_len (saturated to ADDR_BITS) levels below the root; a lookup that meets a missing
// child and an insert that finds the pool full finish earlier, skipping the remaining levels.
// A new word is accepted only once the last one is done, as set by the single node memory read port,
// which is visited once per trie level.
// Reset clears the control state and invalidates the root node through root_valid; no clearing pass.
// ----------------------------------------------------------------------------
// IPv4 prefix trie lookup
// Binary trie longest-prefix match with inserts, held in one node memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv4_prefix_trie_lookup_top_macros.svh"

module ipv4_prefix_trie_lookup_top #(
  parameter int NODES      = 1024,
  parameter int LABEL_BITS = 32,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] address,
  input  logic [5:0]  prefix_len,
  input  logic [31:0] label_value,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] match_label
);
  import iptrie_pkg::*;

  localparam int NB  = $clog2(NODES);
  localparam int NFW = NB + 1;
  localparam int LW  = $clog2(ADDR_BITS + 1);
  localparam logic [NFW-1:0] NODES_W = NFW'(NODES);

  typedef struct packed {
    logic                  active;
    logic [LABEL_BITS-1:0] label;
    logic [NB-1:0]         c1;
    logic [NB-1:0]         c0;
  } node_t;

  node_t mem [NODES];
  node_t mem_rdata;
  logic          we;
  logic [NB-1:0] wa;
  node_t         wd;
  logic [NB-1:0] rd_addr;

  state_t                state, state_next;
  logic [NB-1:0]         node, node_next;
  logic                  fresh, fresh_next;
  logic [LW-1:0]         idx, idx_next;
  logic [LW-1:0]         len_q, len_q_next;
  logic [ADDR_BITS-1:0]  addr_sh, addr_sh_next;
  logic                  op_q, op_q_next;
  logic [LABEL_BITS-1:0] label_q, label_q_next;
  logic                  found, found_next;
  logic [LABEL_BITS-1:0] best, best_next;
  logic [NFW-1:0]        next_free, next_free_next;
  logic                  root_valid, root_valid_next;
  logic                  done_next;
  logic [1:0]            status_next;
  logic [31:0]           match_label_next;

  node_t                 cur;
  logic [NB-1:0]         child;
  logic                  child_ok;
  logic                  found_now;
  logic [LABEL_BITS-1:0] best_now;
  logic [63:0]           best_ext;
  logic [63:0]           label_ext;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_rdata <= mem[rd_addr];
  end

  assign cur       = fresh ? '0 : mem_rdata;
  assign child     = addr_sh[ADDR_BITS-1] ? cur.c1 : cur.c0;
  assign child_ok  = (child != '0) && (int'(child) < NODES);
  assign found_now = found | cur.active;
  assign best_now  = cur.active ? cur.label : best;
  assign best_ext  = 64'(best_now);
  assign label_ext = 64'(label_value);
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      next_free  <= NFW'(1);
      root_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      next_free  <= next_free_next;
      root_valid <= root_valid_next;
      done       <= done_next;
    end
    node        <= node_next;
    fresh       <= fresh_next;
    idx         <= idx_next;
    len_q       <= len_q_next;
    addr_sh     <= addr_sh_next;
    op_q        <= op_q_next;
    label_q     <= label_q_next;
    found       <= found_next;
    best        <= best_next;
    status      <= status_next;
    match_label <= match_label_next;
  end

  always_comb begin
    state_next       = state;
    node_next        = node;
    fresh_next       = fresh;
    idx_next         = idx;
    len_q_next       = len_q;
    addr_sh_next     = addr_sh;
    op_q_next        = op_q;
    label_q_next     = label_q;
    found_next       = found;
    best_next        = best;
    next_free_next   = next_free;
    root_valid_next  = root_valid;
    done_next        = 1'b0;
    status_next      = status;
    match_label_next = match_label;
    we               = 1'b0;
    wa               = node;
    wd               = cur;
    rd_addr          = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next   = ST_WALK;
          node_next    = '0;
          fresh_next   = !root_valid;
          idx_next     = '0;
          found_next   = 1'b0;
          op_q_next    = op;
          addr_sh_next = address[ADDR_BITS-1:0];
          label_q_next = label_ext[LABEL_BITS-1:0];
          if (int'(prefix_len) > ADDR_BITS) begin
            len_q_next = LW'(ADDR_BITS);
          end else begin
            len_q_next = LW'(prefix_len);
          end
        end
      end
      ST_WALK: begin
        if (op_q == OP_LOOKUP) begin
          found_next = found_now;
          best_next  = best_now;
          if (idx == len_q || !child_ok) begin
            state_next  = ST_IDLE;
            done_next   = 1'b1;
            status_next = found_now ? STATUS_OK : STATUS_NOMATCH;
            match_label_next = found_now ? best_ext[31:0] : 32'd0;
          end else begin
            node_next    = child;
            rd_addr      = child;
            fresh_next   = 1'b0;
            idx_next     = idx + LW'(1);
            addr_sh_next = addr_sh << 1;
          end
        end else begin
          if (idx == len_q) begin
            we        = 1'b1;
            wd.active = 1'b1;
            wd.label  = label_q;
            if (node == '0) begin
              root_valid_next = 1'b1;
            end
            state_next       = ST_IDLE;
            done_next        = 1'b1;
            status_next      = STATUS_OK;
            match_label_next = 32'd0;
          end else if (child_ok) begin
            node_next    = child;
            rd_addr      = child;
            fresh_next   = 1'b0;
            idx_next     = idx + LW'(1);
            addr_sh_next = addr_sh << 1;
          end else if (next_free >= NODES_W) begin
            // A freshly allocated node is already linked, so it is cleared here.
            we               = fresh;
            state_next       = ST_IDLE;
            done_next        = 1'b1;
            status_next      = STATUS_FULL;
            match_label_next = 32'd0;
          end else begin
            we = 1'b1;
            if (addr_sh[ADDR_BITS-1]) begin
              wd.c1 = next_free[NB-1:0];
            end else begin
              wd.c0 = next_free[NB-1:0];
            end
            if (node == '0) begin
              root_valid_next = 1'b1;
            end
            node_next      = next_free[NB-1:0];
            next_free_next = next_free + NFW'(1);
            fresh_next     = 1'b1;
            idx_next       = idx + LW'(1);
            addr_sh_next   = addr_sh << 1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `IPT_ASSERT_IMP(a_done_idle, clk, rst, done, state == ST_IDLE)
  `IPT_ASSERT_IMP(a_pool_bound, clk, rst, 1'b1, next_free <= NODES_W)
  `IPT_ASSERT_IMP(a_write_alloc, clk, rst, we, {1'b0, wa} < next_free)
  `IPT_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)

endmodule

// ===== sim/ipv4_prefix_trie_lookup_top_tb.sv =====
// ----------------------------------------------------------------------------
// IPv4 prefix trie lookup testbench
// Sends insert and lookup words through the start/busy handshake. A local
// trie model predicts the status and label of every word, and each done
// strobe is checked against the oldest prediction. The run covers directed
// corner cases, random mixed traffic around a few shared prefixes, and pool
// exhaustion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_prefix_trie_lookup_top_tb;
  import iptrie_pkg::*;

  localparam int POOL_SIZE = 1024;
  localparam int MAX_DEPTH = 32;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] label;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        op;
  logic [31:0] address;
  logic [5:0]  prefix_len;
  logic [31:0] label_value;
  logic        done;
  logic [1:0]  status;
  logic [31:0] match_label;

  logic        trie_active [POOL_SIZE];
  logic [31:0] trie_label  [POOL_SIZE];
  logic [9:0]  trie_zero   [POOL_SIZE];
  logic [9:0]  trie_one    [POOL_SIZE];
  int          trie_next_free;

  answer_t     answer_q[$];
  int          err_count;
  int          burst_left;
  logic [31:0] bases [16];
  logic [31:0] recent_addr [$];

  ipv4_prefix_trie_lookup_top uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .address     (address),
    .prefix_len  (prefix_len),
    .label_value (label_value),
    .done        (done),
    .status      (status),
    .match_label (match_label)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic flag_mismatch(input string msg);
    if (err_count < 100) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  function automatic answer_t walk_trie(input logic w_op, input logic [31:0] w_addr,
                                        input logic [5:0] w_len, input logic [31:0] w_lab);
    answer_t ans;
    int      depth;
    int      node;
    int      child;
    int      i;
    logic    bit_val;
    logic    full;
    logic    found;
    logic    stop;
    ans.status = STATUS_OK;
    ans.label  = '0;
    depth = (w_len > MAX_DEPTH) ? MAX_DEPTH : w_len;
    node  = 0;
    if (w_op == OP_INSERT) begin
      full = 1'b0;
      for (i = 0; i < depth && !full; i++) begin
        bit_val = w_addr[31 - i];
        child = bit_val ? trie_one[node] : trie_zero[node];
        if (child == 0) begin
          if (trie_next_free >= POOL_SIZE) begin
            full = 1'b1;
          end else begin
            child = trie_next_free;
            trie_next_free++;
            trie_active[child] = 1'b0;
            trie_label[child]  = '0;
            trie_zero[child]   = '0;
            trie_one[child]    = '0;
            if (bit_val) trie_one[node] = child[9:0];
            else trie_zero[node] = child[9:0];
          end
        end
        if (!full) node = child;
      end
      if (full) begin
        ans.status = STATUS_FULL;
      end else begin
        trie_active[node] = 1'b1;
        trie_label[node]  = w_lab;
      end
    end else begin
      found = 1'b0;
      stop  = 1'b0;
      i     = 0;
      while (!stop) begin
        if (trie_active[node]) begin
          found     = 1'b1;
          ans.label = trie_label[node];
        end
        if (i >= depth) begin
          stop = 1'b1;
        end else begin
          node = w_addr[31 - i] ? trie_one[node] : trie_zero[node];
          i++;
          if (node == 0) stop = 1'b1;
        end
      end
      if (!found) begin
        ans.status = STATUS_NOMATCH;
        ans.label  = '0;
      end
    end
    return ans;
  endfunction

  // Called at a rising edge; returns at the edge that accepted the word, or after the idle gap that may follow it.
  task automatic issue_word(input logic w_op, input logic [31:0] w_addr,
                            input logic [5:0] w_len, input logic [31:0] w_lab);
    int gap;
    start       <= 1'b1;
    op          <= w_op;
    address     <= w_addr;
    prefix_len  <= w_len;
    label_value <= w_lab;
    do @(posedge clk); while (busy);
    answer_q.push_back(walk_trie(w_op, w_addr, w_len, w_lab));
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
  endtask

  function automatic logic [5:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 6'($urandom_range(0, 24));
    if (r < 95) return 6'($urandom_range(25, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  function automatic logic [31:0] pick_label();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic issue_random_word();
    logic [31:0] a;
    int          r;
    r = $urandom_range(0, 99);
    a = bases[$urandom_range(0, 15)];
    if (r < 10) begin
      issue_word(OP_LOOKUP, $urandom, pick_len(), $urandom);
    end else if (r < 60) begin
      if ($urandom_range(0, 1) == 0) a = a ^ (32'h1 << $urandom_range(0, 31));
      if ($urandom_range(0, 3) == 0) a = a ^ ($urandom & 32'h0000_FFFF);
      issue_word(OP_LOOKUP, a, pick_len(), $urandom);
    end else begin
      if ($urandom_range(0, 3) == 0) a = a ^ (32'h1 << $urandom_range(0, 31));
      issue_word(OP_INSERT, a, pick_len(), pick_label());
    end
  endtask

  task automatic test_directed();
    issue_word(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0000_0000);
    issue_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
    issue_word(OP_INSERT, 32'h0A00_0000, 6'd8, 32'h0000_0008);
    issue_word(OP_INSERT, 32'h0A01_0000, 6'd16, 32'h0000_0010);
    issue_word(OP_LOOKUP, 32'h0A01_0203, 6'd32, 32'h0000_0000);
    issue_word(OP_LOOKUP, 32'h0A02_0304, 6'd32, 32'h0000_0000);
    issue_word(OP_LOOKUP, 32'h0A01_0203, 6'd12, 32'h0000_0000);
    issue_word(OP_LOOKUP, 32'h0B00_0000, 6'd32, 32'h0000_0000);
    issue_word(OP_LOOKUP, 32'h0A00_0000, 6'd0, 32'h0000_0000);
    issue_word(OP_INSERT, 32'h1234_5678, 6'd0, 32'hFFFF_FFFF);
    issue_word(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0000_0000);
    issue_word(OP_LOOKUP, 32'hC0A8_0101, 6'd63, 32'h0000_0000);
    issue_word(OP_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h0000_0000);
    issue_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd32, 32'h0000_0000);
    issue_word(OP_LOOKUP, 32'hFFFF_FFFE, 6'd32, 32'h0000_0000);
    issue_word(OP_INSERT, 32'h0000_0000, 6'd32, 32'hFFFF_FFFF);
    issue_word(OP_LOOKUP, 32'h0000_0000, 6'd33, 32'h0000_0000);
    issue_word(OP_INSERT, 32'h0A00_0000, 6'd8, 32'hA5A5_5A5A);
    issue_word(OP_LOOKUP, 32'h0AFF_FFFF, 6'd32, 32'h0000_0000);
    issue_word(OP_INSERT, 32'h8000_0001, 6'd33, 32'h5555_AAAA);
    issue_word(OP_LOOKUP, 32'h8000_0001, 6'd40, 32'h0000_0000);
    issue_word(OP_LOOKUP, 32'h8000_0001, 6'd31, 32'h0000_0000);
    issue_word(OP_INSERT, 32'h8000_0000, 6'd1, 32'h0000_0001);
    issue_word(OP_LOOKUP, 32'hFFFF_0000, 6'd1, 32'h0000_0000);
    drain_results();
  endtask

  task automatic test_random_mix();
    int chunk;
    for (chunk = 0; chunk < 4; chunk++) begin
      repeat (275) issue_random_word();
      drain_results();
    end
  endtask

  task automatic test_pool_full();
    logic [31:0] a;
    repeat (80) begin
      a = $urandom;
      recent_addr.push_back(a);
      issue_word(OP_INSERT, a, 6'd32, pick_label());
    end
    repeat (20) begin
      issue_word(OP_LOOKUP, recent_addr[$urandom_range(0, recent_addr.size() - 1)],
                 6'd32, 32'h0000_0000);
    end
    repeat (30) issue_random_word();
    drain_results();
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        flag_mismatch($sformatf("result with none outstanding, status %0d label %h",
                                status, match_label));
      end else begin
        want = answer_q.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status got %0d expected %0d", status, want.status));
        if (match_label !== want.label)
          flag_mismatch($sformatf("match_label got %h expected %h", match_label, want.label));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int i;
    rst         <= 1'b1;
    start       <= 1'b0;
    op          <= OP_INSERT;
    address     <= '0;
    prefix_len  <= '0;
    label_value <= '0;
    err_count      = 0;
    burst_left     = 10;
    trie_next_free = 1;
    for (i = 0; i < POOL_SIZE; i++) begin
      trie_active[i] = 1'b0;
      trie_label[i]  = '0;
      trie_zero[i]   = '0;
      trie_one[i]    = '0;
    end
    for (i = 0; i < 16; i++) bases[i] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_pool_full();
    drain_results();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
